### rtl/kte_pkg.sv
// shared types and constants for the keyed entry table
package kte_pkg;

    localparam int KEY_BITS  = 16;
    localparam int NAME_BITS = 64;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        cmd_t                 command;
        logic [KEY_BITS-1:0]  key;
        logic [KEY_BITS-1:0]  entry_key;
        logic [NAME_BITS-1:0] entry_name;
    } in_word_t;

    typedef struct packed {
        logic                 found;
        logic                 full_res;
        logic [KEY_BITS-1:0]  result_key;
        logic [NAME_BITS-1:0] result_name;
        logic [CNT_W-1:0]     entry_count;
    } out_word_t;

    typedef struct packed {
        logic                 apply;
        logic                 add_ok;
        cmd_t                 command;
        logic [KEY_BITS-1:0]  key;
        logic [KEY_BITS-1:0]  entry_key;
        logic [NAME_BITS-1:0] entry_name;
        logic [CNT_W-1:0]     count;
    } cell_ctl_t;

endpackage

### rtl/keyed_entry_table.sv
// top level: ordered key and name table built from a row of slot cells
// the input word is registered on accept, then the execute state writes the result into the output register
// a new command is accepted only in the idle state, after the compare and shift pass over the cells for the last one
// the execute cycle waits while a previous result is still held in the output register
// reset: fill count cleared, capacity set to 16, entry storage left undefined
module keyed_entry_table #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  kte_pkg::in_word_t          s_word,
    output logic                       m_valid,
    input  logic                       m_ready,
    output kte_pkg::out_word_t         m_word,
    input  logic                       cfg_we,
    input  logic [kte_pkg::CNT_W-1:0]  cfg_data
);
    import kte_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t               state_reg, state_next;
    in_word_t             item_reg;
    logic [CNT_W-1:0]     capacity_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_word_reg, m_word_next;
    logic [CNT_W-1:0]     limit;
    logic                 out_free;
    cell_ctl_t            ctl;

    logic [DEPTH:0]       hit_chain;
    logic [DEPTH-1:0]     first_vec;
    logic [KEY_BITS-1:0]  cell_key  [DEPTH];
    logic [NAME_BITS-1:0] cell_name [DEPTH];
    logic [KEY_BITS-1:0]  sel_key;
    logic [NAME_BITS-1:0] sel_name;
    logic                 found;

    assign limit    = (32'(capacity_reg) > DEPTH) ? CNT_W'(DEPTH) : capacity_reg;
    assign out_free = ~m_valid_reg | m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;

    assign ctl.apply      = (state_reg == ST_EXEC) && out_free;
    assign ctl.add_ok     = count_reg < limit;
    assign ctl.command    = item_reg.command;
    assign ctl.key        = item_reg.key;
    assign ctl.entry_key  = item_reg.entry_key;
    assign ctl.entry_name = item_reg.entry_name;
    assign ctl.count      = count_reg;

    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_BITS-1:0]  nbr_key;
        logic [NAME_BITS-1:0] nbr_name;
        if (i == DEPTH - 1) begin : g_last
            assign nbr_key  = '0;
            assign nbr_name = '0;
        end else begin : g_mid
            assign nbr_key  = cell_key[i+1];
            assign nbr_name = cell_name[i+1];
        end
        kte_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .nbr_key  (nbr_key),
            .nbr_name (nbr_name),
            .hit_in   (hit_chain[i]),
            .hit_out  (hit_chain[i+1]),
            .first    (first_vec[i]),
            .key_out  (cell_key[i]),
            .name_out (cell_name[i])
        );
    end

    // one-hot select of the first matching slot
    always_comb begin
        sel_key  = '0;
        sel_name = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_key  = sel_key  | (cell_key[i]  & {KEY_BITS{first_vec[i]}});
            sel_name = sel_name | (cell_name[i] & {NAME_BITS{first_vec[i]}});
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_word_next  = m_word_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_word_next = '0;
                    case (item_reg.command)
                        CMD_ADD: begin
                            if (ctl.add_ok) begin
                                count_next = count_reg + 1'b1;
                            end else begin
                                m_word_next.full_res = 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            m_word_next.found = found;
                            if (found) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_UPDATE: begin
                            m_word_next.found = found;
                        end
                        CMD_GET: begin
                            m_word_next.found       = found;
                            m_word_next.result_key  = sel_key;
                            m_word_next.result_name = sel_name;
                        end
                        default: begin
                        end
                    endcase
                    m_word_next.entry_count = count_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_word;
        end
        m_word_reg <= m_word_next;
    end

endmodule

### rtl/kte_cell.sv
// one table slot: holds an entry, compares its key and shifts from its neighbor
module kte_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                         aclk,
    input  kte_pkg::cell_ctl_t           ctl,
    input  logic [kte_pkg::KEY_BITS-1:0]  nbr_key,
    input  logic [kte_pkg::NAME_BITS-1:0] nbr_name,
    input  logic                         hit_in,
    output logic                         hit_out,
    output logic                         first,
    output logic [kte_pkg::KEY_BITS-1:0]  key_out,
    output logic [kte_pkg::NAME_BITS-1:0] name_out
);
    import kte_pkg::*;

    localparam int CMP_W = IDX_W + CNT_W + 1;

    logic [KEY_BITS-1:0]  key_reg;
    logic [NAME_BITS-1:0] name_reg;
    logic                 occupied;
    logic                 is_tail;
    logic                 match;

    assign occupied = CMP_W'(ctl.count) > CMP_W'(INDEX);
    assign is_tail  = CMP_W'(ctl.count) == CMP_W'(INDEX);
    assign match    = occupied && (key_reg == ctl.key);
    assign hit_out  = hit_in | match;
    assign first    = match & ~hit_in;
    assign key_out  = key_reg;
    assign name_out = name_reg;

    always_ff @(posedge aclk) begin
        if (ctl.apply) begin
            case (ctl.command)
                CMD_ADD: begin
                    if (ctl.add_ok && is_tail) begin
                        key_reg  <= ctl.entry_key;
                        name_reg <= ctl.entry_name;
                    end
                end
                CMD_DELETE: begin
                    if (hit_out) begin
                        key_reg  <= nbr_key;
                        name_reg <= nbr_name;
                    end
                end
                CMD_UPDATE: begin
                    if (match) begin
                        key_reg  <= ctl.entry_key;
                        name_reg <= ctl.entry_name;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### tb/keyed_entry_table_test.sv
// self-checking testbench for the keyed entry table: directed table, then random command phases
module keyed_entry_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kte_pkg::*;

    localparam int TBL_DEPTH     = 16;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 4;
    localparam int POOL_SIZE     = 6;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_WORDS   = 95;
    localparam int DIRECTED_ROWS = 29;

    localparam logic [KEY_BITS-1:0]  KEY_MAX  = 16'hFFFF;
    localparam logic [NAME_BITS-1:0] NAME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [NAME_BITS-1:0] NAME_A   = 64'h0123_4567_89AB_CDEF;
    localparam logic [NAME_BITS-1:0] NAME_B   = 64'hA5A5_5A5A_C3C3_3C3C;

    localparam logic [CNT_W-1:0] EXTREME_CAPS [4] = '{5'd16, 5'd31, 5'd1, 5'd0};

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    typedef struct {
        bit               is_cap;
        logic [CNT_W-1:0] cap;
        in_word_t         word;
        bit               typed;
        out_word_t        want;
    } row_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_word_t         s_word;
    logic             m_valid;
    logic             m_ready;
    out_word_t        m_word;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;

    // table mirror
    logic [KEY_BITS-1:0]  tbl_key  [TBL_DEPTH];
    logic [NAME_BITS-1:0] tbl_name [TBL_DEPTH];
    int unsigned          tbl_fill;
    logic [CNT_W-1:0]     tbl_cap;

    out_word_t           awaited_results [$];
    row_t                directed [DIRECTED_ROWS];
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    bit                  failed = 1'b0;
    bit                  tx_quiet;
    bit                  rx_quiet;

    keyed_entry_table #(
        .DEPTH(TBL_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_word_t table_apply(in_word_t w);
        out_word_t   r;
        int unsigned lim;
        int unsigned i;
        int          hit;
        r   = '0;
        lim = (tbl_cap > TBL_DEPTH) ? TBL_DEPTH : tbl_cap;
        hit = -1;
        for (i = 0; i < tbl_fill; i++) begin
            if (hit < 0 && tbl_key[i] == w.key) begin
                hit = i;
            end
        end
        case (w.command)
            CMD_ADD: begin
                if (tbl_fill >= lim) begin
                    r.full_res = 1'b1;
                end else begin
                    tbl_key[tbl_fill]  = w.entry_key;
                    tbl_name[tbl_fill] = w.entry_name;
                    tbl_fill++;
                end
            end
            CMD_DELETE: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    for (i = hit; i + 1 < tbl_fill; i++) begin
                        tbl_key[i]  = tbl_key[i+1];
                        tbl_name[i] = tbl_name[i+1];
                    end
                    tbl_fill--;
                end
            end
            CMD_UPDATE: begin
                for (i = 0; i < tbl_fill; i++) begin
                    if (tbl_key[i] == w.key) begin
                        r.found     = 1'b1;
                        tbl_key[i]  = w.entry_key;
                        tbl_name[i] = w.entry_name;
                    end
                end
            end
            default: begin
                if (hit >= 0) begin
                    r.found       = 1'b1;
                    r.result_key  = tbl_key[hit];
                    r.result_name = tbl_name[hit];
                end
            end
        endcase
        r.entry_count = CNT_W'(tbl_fill);
        return r;
    endfunction

    function automatic row_t word_row(cmd_t c, logic [KEY_BITS-1:0] k,
                                      logic [KEY_BITS-1:0] ek, logic [NAME_BITS-1:0] en);
        row_t r;
        r.is_cap = 1'b0;
        r.cap    = '0;
        r.word   = '{command: c, key: k, entry_key: ek, entry_name: en};
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic row_t checked_row(cmd_t c, logic [KEY_BITS-1:0] k,
                                         logic [KEY_BITS-1:0] ek, logic [NAME_BITS-1:0] en,
                                         logic f, logic fl, logic [KEY_BITS-1:0] rk,
                                         logic [NAME_BITS-1:0] rn, logic [CNT_W-1:0] cnt);
        row_t r;
        r       = word_row(c, k, ek, en);
        r.typed = 1'b1;
        r.want  = '{found: f, full_res: fl, result_key: rk, result_name: rn, entry_count: cnt};
        return r;
    endfunction

    function automatic row_t cap_row(logic [CNT_W-1:0] v);
        row_t r;
        r        = word_row(CMD_GET, '0, '0, '0);
        r.is_cap = 1'b1;
        r.cap    = v;
        return r;
    endfunction

    function automatic in_word_t random_word(mix_t mix);
        in_word_t w;
        int       r;
        int       a;
        int       d;
        int       u;
        w.key        = ($urandom_range(0, 6) == 0) ? KEY_BITS'($urandom)
                                                   : key_pool[$urandom_range(0, POOL_SIZE-1)];
        w.entry_key  = ($urandom_range(0, 9) == 0) ? KEY_BITS'($urandom)
                                                   : key_pool[$urandom_range(0, POOL_SIZE-1)];
        w.entry_name = {$urandom, $urandom};
        case (mix)
            MIX_FILL:  begin a = 60; d = 75; u = 85; end
            MIX_DRAIN: begin a = 20; d = 65; u = 75; end
            default:   begin a = 25; d = 50; u = 75; end
        endcase
        r = $urandom_range(0, 99);
        if (r < a) begin
            w.command = CMD_ADD;
        end else if (r < d) begin
            w.command = CMD_DELETE;
        end else if (r < u) begin
            w.command = CMD_UPDATE;
        end else begin
            w.command = CMD_GET;
        end
        // occasional noise word
        if ($urandom_range(0, 19) == 0) begin
            w = '{command: cmd_t'($urandom_range(0, 3)), key: KEY_BITS'($urandom),
                  entry_key: KEY_BITS'($urandom), entry_name: {$urandom, $urandom}};
        end
        return w;
    endfunction

    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we   <= 1'b0;
        tbl_cap = v;
    endtask

    task automatic issue_word(in_word_t w, bit typed, out_word_t want);
        int        gap;
        out_word_t got;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = table_apply(w);
        awaited_results.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int   i;
        int   ph;
        int   j;
        mix_t mix;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_word   = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        tbl_cap  = CAPACITY_RESET;
        tbl_fill = 0;

        directed = '{
            // empty table
            checked_row(CMD_GET,    '0,      '0,      '0,       0, 0, '0, '0, 5'd0),
            checked_row(CMD_DELETE, KEY_MAX, '0,      '0,       0, 0, '0, '0, 5'd0),
            checked_row(CMD_UPDATE, '0,      KEY_MAX, NAME_MAX, 0, 0, '0, '0, 5'd0),
            checked_row(CMD_ADD,    '0,      KEY_MAX, NAME_MAX, 0, 0, '0, '0, 5'd1),
            checked_row(CMD_ADD,    KEY_MAX, '0,      '0,       0, 0, '0, '0, 5'd2),
            // repeated key
            checked_row(CMD_ADD,    '0,      KEY_MAX, NAME_A,   0, 0, '0, '0, 5'd3),
            word_row(CMD_GET,    KEY_MAX, '0,       '0),
            word_row(CMD_UPDATE, KEY_MAX, 16'h1234, NAME_B),
            word_row(CMD_GET,    16'h1234, '0, '0),
            word_row(CMD_DELETE, 16'h1234, '0, '0),
            word_row(CMD_GET,    16'h1234, '0, '0),
            word_row(CMD_GET,    '0,       '0, '0),
            word_row(CMD_DELETE, '0,       '0, '0),
            // capacity zero
            cap_row(5'd0),
            checked_row(CMD_ADD, '0, 16'h5555, NAME_A, 0, 1, '0, '0, 5'd1),
            cap_row(5'd1),
            checked_row(CMD_ADD, '0, 16'h5555, NAME_A, 0, 1, '0, '0, 5'd1),
            word_row(CMD_DELETE, 16'h1234, '0, '0),
            word_row(CMD_ADD,    '0, 16'h0001, NAME_A),
            checked_row(CMD_ADD, '0, 16'h5555, NAME_B, 0, 1, '0, '0, 5'd1),
            // capacity above the table depth
            cap_row(5'd31),
            word_row(CMD_ADD, '0, 16'h8000, NAME_B),
            word_row(CMD_ADD, '0, 16'h7FFF, NAME_MAX),
            // capacity lowered below the fill count
            cap_row(5'd2),
            checked_row(CMD_ADD, '0, 16'h5555, NAME_A, 0, 1, '0, '0, 5'd3),
            word_row(CMD_DELETE, 16'h8000, '0, '0),
            checked_row(CMD_ADD, '0, 16'h5555, NAME_A, 0, 1, '0, '0, 5'd2),
            word_row(CMD_DELETE, 16'h0001, '0, '0),
            word_row(CMD_ADD,    '0, 16'hAAAA, NAME_B)
        };

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].is_cap) begin
                set_capacity(directed[i].cap);
            end else begin
                issue_word(directed[i].word, directed[i].typed, directed[i].want);
            end
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_capacity(ph < 4 ? EXTREME_CAPS[ph] : CNT_W'($urandom_range(1, 16)));
            for (j = 0; j < POOL_SIZE; j++) begin
                key_pool[j] = KEY_BITS'($urandom);
            end
            if ($urandom_range(0, 2) == 0) begin
                key_pool[0] = '0;
                key_pool[1] = KEY_MAX;
            end
            mix      = (ph < 2) ? MIX_FILL : mix_t'($urandom_range(0, 2));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            for (j = 0; j < PHASE_WORDS; j++) begin
                if ($urandom_range(0, 49) == 0) begin
                    settle();
                end
                issue_word(random_word(mix), 1'b0, '0);
            end
        end

        settle();
        repeat (10) @(negedge aclk);
        if (!failed) begin
            $display("keyed_entry_table_test: clean");
        end else begin
            $display("keyed_entry_table_test: errors");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        out_word_t want;
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result word with none expected");
                failed = 1'b1;
            end else begin
                want = awaited_results.pop_front();
                if (m_word.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_word.found);
                    failed = 1'b1;
                end
                if (m_word.full_res !== want.full_res) begin
                    $error("full_res: expected %0d, got %0d", want.full_res, m_word.full_res);
                    failed = 1'b1;
                end
                if (m_word.result_key !== want.result_key) begin
                    $error("result_key: expected %h, got %h", want.result_key, m_word.result_key);
                    failed = 1'b1;
                end
                if (m_word.result_name !== want.result_name) begin
                    $error("result_name: expected %h, got %h",
                           want.result_name, m_word.result_name);
                    failed = 1'b1;
                end
                if (m_word.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_word.entry_count);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("keyed_entry_table_test: errors");
        $finish;
    end

endmodule

### files.f
rtl/kte_pkg.sv
rtl/kte_cell.sv
rtl/keyed_entry_table.sv
tb/keyed_entry_table_test.sv
